FILE: hdl/atr_pkg.sv
// ----------------------------------------------------------------------------
// atr_pkg: shared types and constants for the averaged thermostat relay
// Field widths, action codes, register indexes and divider status.
// ----------------------------------------------------------------------------
package atr_pkg;

    localparam int READ_W   = 12;  // converter value, quarter degrees
    localparam int SAMPLE_W = 14;  // offset-corrected sample, quarter degrees
    localparam int SET_W    = 10;
    localparam int OFF_W    = 10;
    localparam int SMOOTH_W = 12;
    localparam int LMEAN_W  = 16;
    localparam int LFILL_W  = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef enum logic [1:0] {
        ACT_READING = 2'd0,
        ACT_CONTROL = 2'd1,
        ACT_MINUTE  = 2'd2,
        ACT_CLEAR   = 2'd3
    } t_action;

    typedef enum logic {
        REG_SETPOINT = 1'b0,
        REG_OFFSET   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: hdl/atr_if.sv
// ----------------------------------------------------------------------------
// atr_if: valid/ready channels of the averaged thermostat relay
// One interface for the input beats and one for the result beats.
// ----------------------------------------------------------------------------
interface atr_in_if;
    import atr_pkg::*;

    logic                valid;
    logic                ready;
    t_action             action;
    logic [READ_W-1:0]   reading_quarter;

    modport source (output valid, output action, output reading_quarter, input ready);
    modport sink   (input valid, input action, input reading_quarter, output ready);
endinterface

interface atr_out_if;
    import atr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SMOOTH_W-1:0] smoothed_deg;
    logic                       relay_on;
    logic                       reached_set;
    logic signed [LMEAN_W-1:0]  long_mean_x16;
    logic [LFILL_W-1:0]         long_filled;

    modport source (output valid, output smoothed_deg, output relay_on, output reached_set,
                    output long_mean_x16, output long_filled, input ready);
    modport sink   (input valid, input smoothed_deg, input relay_on, input reached_set,
                    input long_mean_x16, input long_filled, output ready);
endinterface

FILE: hdl/atr_regs.sv
// ----------------------------------------------------------------------------
// atr_regs: APB configuration registers
// Holds the setpoint and the calibration offset; writes complete in the
// access phase and reads return the stored value.
// ----------------------------------------------------------------------------
module atr_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [atr_pkg::PADDR_W-1:0]    paddr,
    input  logic [atr_pkg::PDATA_W-1:0]    pwdata,
    output logic [atr_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output logic [atr_pkg::SET_W-1:0]      o_setpoint,
    output logic signed [atr_pkg::OFF_W-1:0] o_offset
);
    import atr_pkg::*;

    logic [SET_W-1:0]        r_setpoint;
    logic signed [OFF_W-1:0] r_offset;
    logic                    wr_en;
    t_reg_idx                reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_offset   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SETPOINT: r_setpoint <= pwdata[SET_W-1:0];
                REG_OFFSET:   r_offset   <= pwdata[OFF_W-1:0];
                default:      r_setpoint <= r_setpoint;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SETPOINT: prdata = PDATA_W'(r_setpoint);
            REG_OFFSET:   prdata = PDATA_W'(unsigned'(r_offset));
            default:      prdata = '0;
        endcase
    end

    assign o_setpoint = r_setpoint;
    assign o_offset   = r_offset;

endmodule

FILE: hdl/atr_div.sv
// ----------------------------------------------------------------------------
// atr_div: shared iterative divider with rounding
// Signed numerator over a positive denominator, rounded half away from zero.
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atr_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 9
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output atr_pkg::t_div_stat      o_stat,
    output logic signed [NUM_W-1:0] o_quo
);
    import atr_pkg::*;

    localparam int Q_W   = NUM_W + 1;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [Q_W-1:0]   r_dvd;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             q_bit;
    logic [DEN_W-1:0] n_rem;
    logic [Q_W-1:0]   quo_full;

    always_comb begin
        mag     = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        rem_sh  = {r_rem, r_dvd[Q_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = (rem_sh >= {1'b0, r_den});
        n_rem   = q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        // The quotient is small, so the low bits after negation are the result.
        quo_full = r_neg ? (~r_dvd + 1'b1) : r_dvd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
                r_dvd  <= {1'b0, mag} + Q_W'(i_den >> 1);
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[NUM_W-1];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[Q_W-2:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = signed'(quo_full[NUM_W-1:0]);

endmodule

FILE: hdl/averaged_thermostat_relay.sv
// ----------------------------------------------------------------------------
// averaged_thermostat_relay: bang-bang heater control with two moving means
// Readings feed a short ring whose rounded mean is the smoothed temperature;
// control ticks drive the relay and the reached latch; minute ticks feed a
// long ring of smoothed values once the setpoint has been reached.
//
//   channel   direction  beat contents
//   i_in      in         action, reading_quarter
//   o_out     out        smoothed_deg, relay_on, reached_set, long_mean_x16,
//                        long_filled
//   APB       in/out     setpoint_deg at 0x0, offset_quarter at 0x4
//
// A reading or a counted minute tick passes through the update, start,
// divide and done steps, the divide step using the bit-serial divider that
// both rings share. A control tick, a clear and an uncounted minute tick go
// straight to the done step, which loads the output register once it is free.
// One input beat is worked on at a time; a finished result waits in the
// output register while the next beat is taken in. Reset is synchronous and
// needs no clearing pass: ring entries past the fill count read as zero.
// ----------------------------------------------------------------------------
module averaged_thermostat_relay #(
    parameter int SHORT_DEPTH = 8,
    parameter int LONG_DEPTH  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    atr_in_if.sink                      i_in,
    atr_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [atr_pkg::PADDR_W-1:0] paddr,
    input  logic [atr_pkg::PDATA_W-1:0] pwdata,
    output logic [atr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import atr_pkg::*;

    localparam int SF_W  = $clog2(SHORT_DEPTH + 1);
    localparam int LF_W  = $clog2(LONG_DEPTH + 1);
    localparam int SP_W  = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
    localparam int LP_W  = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
    localparam int ST_W  = SAMPLE_W + SF_W;
    localparam int LT_W  = SMOOTH_W + LF_W;
    localparam int NUM_W = (ST_W > LT_W + 4) ? ST_W : LT_W + 4;
    localparam int DEN_W = (SF_W + 2 > LF_W) ? SF_W + 2 : LF_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_START,
        S_DIVIDE,
        S_DONE
    } t_state;

    // Configuration.
    logic [SET_W-1:0]        setpoint;
    logic signed [OFF_W-1:0] offset;

    // Sequencer and held state.
    t_state                     r_state;
    t_action                    r_action;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [SP_W-1:0]            r_short_pos;
    logic [SF_W-1:0]            r_short_filled;
    logic signed [ST_W-1:0]     r_short_total;
    logic signed [SMOOTH_W-1:0] r_smoothed;
    logic                       r_relay;
    logic                       r_reached;
    logic [LP_W-1:0]            r_long_pos;
    logic [LF_W-1:0]            r_long_count;
    logic signed [LT_W-1:0]     r_long_total;
    logic signed [LMEAN_W-1:0]  r_long_mean;

    // Result register.
    logic                       r_out_valid;
    logic signed [SMOOTH_W-1:0] r_out_smoothed;
    logic                       r_out_relay;
    logic                       r_out_reached;
    logic signed [LMEAN_W-1:0]  r_out_mean;
    logic [LFILL_W-1:0]         r_out_filled;

    // Ring memories.
    logic signed [SAMPLE_W-1:0] r_short_ring [SHORT_DEPTH];
    logic signed [SMOOTH_W-1:0] r_long_ring  [LONG_DEPTH];
    logic signed [SAMPLE_W-1:0] r_short_rd;
    logic signed [SMOOTH_W-1:0] r_long_rd;

    // Combinational helpers.
    logic                       in_take;
    logic                       out_free;
    logic signed [SAMPLE_W-1:0] new_sample;
    logic signed [ST_W-1:0]     short_old;
    logic signed [LT_W-1:0]     long_old;
    logic [SP_W-1:0]            short_pos_nx;
    logic [LP_W-1:0]            long_pos_nx;
    logic                       short_full;
    logic                       long_full;
    logic signed [SET_W+2:0]    smooth_cmp;
    logic signed [SET_W+2:0]    set_cmp;
    logic                       div_start;
    logic signed [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]           div_den;
    t_div_stat                  div_stat;
    logic signed [NUM_W-1:0]    div_quo;

    atr_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_setpoint (setpoint),
        .o_offset   (offset)
    );

    atr_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_take    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        new_sample = SAMPLE_W'(i_in.reading_quarter) + SAMPLE_W'(offset);
        short_full = (r_short_filled == SF_W'(SHORT_DEPTH));
        long_full  = (r_long_count == LF_W'(LONG_DEPTH));
        // While a ring is still filling, the slot under the pointer is unused.
        short_old  = short_full ? ST_W'(r_short_rd) : '0;
        long_old   = long_full ? LT_W'(r_long_rd) : '0;
        short_pos_nx = (r_short_pos == SP_W'(SHORT_DEPTH - 1)) ? '0 : r_short_pos + 1'b1;
        long_pos_nx  = (r_long_pos == LP_W'(LONG_DEPTH - 1)) ? '0 : r_long_pos + 1'b1;
        smooth_cmp = (SET_W + 3)'(r_smoothed);
        set_cmp    = signed'({3'b000, setpoint});
        div_start  = (r_state == S_START);
        if (r_action == ACT_READING) begin
            div_num = NUM_W'(r_short_total);
            div_den = DEN_W'({r_short_filled, 2'b00});
        end else begin
            div_num = NUM_W'(r_long_total) <<< 4;
            div_den = DEN_W'(r_long_count);
        end
    end

    always_ff @(posedge i_clk) begin
        r_short_rd <= r_short_ring[r_short_pos];
        r_long_rd  <= r_long_ring[r_long_pos];
        if (r_state == S_UPDATE && r_action == ACT_READING) begin
            r_short_ring[r_short_pos] <= r_sample;
        end
        if (r_state == S_UPDATE && r_action == ACT_MINUTE) begin
            r_long_ring[r_long_pos] <= r_smoothed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_action       <= ACT_READING;
            r_short_pos    <= '0;
            r_short_filled <= '0;
            r_short_total  <= '0;
            r_smoothed     <= '0;
            r_relay        <= 1'b0;
            r_reached      <= 1'b0;
            r_long_pos     <= '0;
            r_long_count   <= '0;
            r_long_total   <= '0;
            r_long_mean    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            // The done step reloads the result register itself.
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_action <= i_in.action;
                        r_sample <= new_sample;
                        case (i_in.action)
                            ACT_READING: r_state <= S_UPDATE;
                            ACT_CONTROL: begin
                                if (smooth_cmp >= set_cmp) begin
                                    r_reached <= 1'b1;
                                end
                                r_relay <= (smooth_cmp <= set_cmp);
                                r_state <= S_DONE;
                            end
                            ACT_MINUTE: r_state <= r_reached ? S_UPDATE : S_DONE;
                            ACT_CLEAR: begin
                                r_short_pos    <= '0;
                                r_short_filled <= '0;
                                r_short_total  <= '0;
                                r_smoothed     <= '0;
                                r_relay        <= 1'b0;
                                r_reached      <= 1'b0;
                                r_long_pos     <= '0;
                                r_long_count   <= '0;
                                r_long_total   <= '0;
                                r_long_mean    <= '0;
                                r_state        <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_UPDATE: begin
                    if (r_action == ACT_READING) begin
                        r_short_total <= r_short_total + ST_W'(r_sample) - short_old;
                        r_short_pos   <= short_pos_nx;
                        if (!short_full) begin
                            r_short_filled <= r_short_filled + 1'b1;
                        end
                    end else begin
                        r_long_total <= r_long_total + LT_W'(r_smoothed) - long_old;
                        r_long_pos   <= long_pos_nx;
                        if (!long_full) begin
                            r_long_count <= r_long_count + 1'b1;
                        end
                    end
                    r_state <= S_START;
                end
                S_START: r_state <= S_DIVIDE;
                S_DIVIDE: begin
                    if (div_stat.done) begin
                        if (r_action == ACT_READING) begin
                            r_smoothed <= SMOOTH_W'(div_quo);
                        end else begin
                            r_long_mean <= LMEAN_W'(div_quo);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_smoothed <= r_smoothed;
                        r_out_relay    <= r_relay;
                        r_out_reached  <= r_reached;
                        r_out_mean     <= r_long_mean;
                        r_out_filled   <= LFILL_W'(r_long_count);
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.smoothed_deg  = r_out_smoothed;
    assign o_out.relay_on      = r_out_relay;
    assign o_out.reached_set   = r_out_reached;
    assign o_out.long_mean_x16 = r_out_mean;
    assign o_out.long_filled   = r_out_filled;

    // While a ring fills, its write pointer must equal its fill count.
    a_short_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !short_full |-> (SF_W'(r_short_pos) == r_short_filled))
        else $error("short ring pointer out of step with its fill count");

    a_long_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !long_full |-> (LF_W'(r_long_pos) == r_long_count))
        else $error("long ring pointer out of step with its fill count");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIVIDE))
        else $error("divider finished outside the divide step");

    a_out_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid)
        else $error("pending result dropped");

endmodule

FILE: tb/thermostat_checker.sv
// ----------------------------------------------------------------------------
// thermostat_checker: result predictor and comparator for the thermostat relay
// Watches the input and result channels and the register port, keeps its own
// copy of both rings, the latches and the registers, and compares every
// result beat field by field against the oldest predicted readout.
// ----------------------------------------------------------------------------
module thermostat_checker #(
    parameter int SHORT_DEPTH = 8,
    parameter int LONG_DEPTH  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    atr_in_if                           in_bus,
    atr_out_if                          out_bus,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [atr_pkg::PADDR_W-1:0] paddr,
    input  logic [atr_pkg::PDATA_W-1:0] pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import atr_pkg::*;

    typedef struct {
        logic signed [SMOOTH_W-1:0] smoothed_deg;
        logic                       relay_on;
        logic                       reached_set;
        logic signed [LMEAN_W-1:0]  long_mean_x16;
        logic [LFILL_W-1:0]         long_filled;
    } t_readout;

    logic [SET_W-1:0]           setpoint;
    logic signed [OFF_W-1:0]    offset_q;

    logic signed [SAMPLE_W-1:0] short_ring [SHORT_DEPTH];
    int unsigned                short_pos;
    int unsigned                short_fill;
    longint                     short_total;
    logic signed [SMOOTH_W-1:0] smoothed;
    logic                       relay;
    logic                       reached;
    logic signed [SMOOTH_W-1:0] long_ring [LONG_DEPTH];
    int unsigned                long_pos;
    int unsigned                long_count;
    longint                     long_total;
    logic signed [LMEAN_W-1:0]  long_mean;

    t_readout expected_readouts [$];
    t_readout fresh;
    t_readout oldest;

    // Division rounded half away from zero; an empty ring gives zero.
    function automatic longint rounded_ratio(input longint num, input longint den);
        if (den <= 0) return 0;
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    task automatic clear_readings();
        foreach (short_ring[k]) short_ring[k] = '0;
        foreach (long_ring[k]) long_ring[k] = '0;
        short_pos   = 0;
        short_fill  = 0;
        short_total = 0;
        smoothed    = '0;
        relay       = 1'b0;
        reached     = 1'b0;
        long_pos    = 0;
        long_count  = 0;
        long_total  = 0;
        long_mean   = '0;
    endtask

    task automatic advance_thermostat(input t_action act, input logic [READ_W-1:0] rq,
                                      output t_readout r);
        longint      sample;
        int unsigned slot;
        case (act)
            ACT_READING: begin
                sample      = longint'(rq) + longint'(offset_q);
                slot        = short_pos;
                short_total += sample - longint'(short_ring[slot]);
                short_ring[slot] = SAMPLE_W'(sample);
                short_pos   = (slot + 1) % SHORT_DEPTH;
                if (short_fill < SHORT_DEPTH) short_fill++;
                smoothed = SMOOTH_W'(rounded_ratio(short_total, 4 * longint'(short_fill)));
            end
            ACT_CONTROL: begin
                if (longint'(smoothed) >= longint'(setpoint)) reached = 1'b1;
                relay = (longint'(smoothed) <= longint'(setpoint));
            end
            ACT_MINUTE: begin
                // Minute ticks only count once the setpoint has been reached.
                if (reached) begin
                    slot       = long_pos;
                    long_total += longint'(smoothed) - longint'(long_ring[slot]);
                    long_ring[slot] = smoothed;
                    long_pos   = (slot + 1) % LONG_DEPTH;
                    if (long_count < LONG_DEPTH) long_count++;
                    long_mean = LMEAN_W'(rounded_ratio(long_total * 16, longint'(long_count)));
                end
            end
            default: begin
                clear_readings();
            end
        endcase
        r.smoothed_deg  = smoothed;
        r.relay_on      = relay;
        r.reached_set   = reached;
        r.long_mean_x16 = long_mean;
        r.long_filled   = LFILL_W'(long_count);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t ns: %s expected %0d, got %0d", $realtime, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_readings();
            setpoint = '0;
            offset_q = '0;
            expected_readouts.delete();
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[2]))
                    REG_SETPOINT: setpoint = pwdata[SET_W-1:0];
                    REG_OFFSET:   offset_q = pwdata[OFF_W-1:0];
                    default: ;
                endcase
            end
            if (in_bus.valid && in_bus.ready) begin
                advance_thermostat(in_bus.action, in_bus.reading_quarter, fresh);
                expected_readouts.push_back(fresh);
            end
            if (out_bus.valid && out_bus.ready) begin
                if (expected_readouts.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t ns: result beat with no reading pending", $realtime);
                    end
                end else begin
                    oldest = expected_readouts.pop_front();
                    check_field("smoothed_deg", oldest.smoothed_deg, out_bus.smoothed_deg);
                    check_field("relay_on", oldest.relay_on, out_bus.relay_on);
                    check_field("reached_set", oldest.reached_set, out_bus.reached_set);
                    check_field("long_mean_x16", oldest.long_mean_x16, out_bus.long_mean_x16);
                    check_field("long_filled", oldest.long_filled, out_bus.long_filled);
                end
            end
        end
        o_pending = expected_readouts.size();
    end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the averaged thermostat relay
// Drives readings and ticks through the input channel with random gaps and
// output stalls, reprograms setpoint and offset between phases, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import atr_pkg::*;

    localparam int SHORT_DEPTH  = 8;
    localparam int LONG_DEPTH   = 16;
    localparam int HOLD_AT      = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_FROM    = 10000;
    localparam int CALM_TO      = 16000;
    localparam int PHASE_BEATS  = 170;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    bit                 gaps_on;

    atr_in_if  in_bus ();
    atr_out_if out_bus ();

    averaged_thermostat_relay #(
        .SHORT_DEPTH(SHORT_DEPTH),
        .LONG_DEPTH (LONG_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    thermostat_checker #(
        .SHORT_DEPTH(SHORT_DEPTH),
        .LONG_DEPTH (LONG_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_bus      (in_bus),
        .out_bus     (out_bus),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("averaged_thermostat_relay: mismatch");
        $finish;
    end

    // Result side: random stalls, one long hold-off that backs the block up,
    // and a window with the receiver always ready.
    initial begin
        int unsigned cyc;
        int unsigned hold_left;
        cyc       = 0;
        hold_left = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc == HOLD_AT) hold_left = HOLD_CYCLES;
            if (hold_left != 0) begin
                out_bus.ready <= 1'b0;
                hold_left--;
            end else if (cyc >= CALM_FROM && cyc < CALM_TO) begin
                out_bus.ready <= 1'b1;
            end else begin
                out_bus.ready <= ($urandom_range(0, 99) >= 24);
            end
        end
    end

    task automatic offer_beat(input t_action act, input logic [READ_W-1:0] rq);
        if (gaps_on && $urandom_range(0, 99) < 24) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_bus.valid           <= 1'b1;
        in_bus.action          <= act;
        in_bus.reading_quarter <= rq;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers change only once every predicted readout has come back.
    task automatic set_registers(input int setpoint, input int offset);
        drain_results();
        write_reg(REG_SETPOINT, PDATA_W'(setpoint));
        write_reg(REG_OFFSET, {{(PDATA_W-OFF_W){1'b0}}, OFF_W'(offset)});
    endtask

    function automatic t_action pick_action();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return ACT_READING;
        if (r < 70) return ACT_CONTROL;
        if (r < 99) return ACT_MINUTE;
        return ACT_CLEAR;
    endfunction

    // Most readings sit around the setpoint so the relay and latch toggle.
    function automatic logic [READ_W-1:0] pick_reading(input int setpoint, input int offset);
        int jitter;
        int target;
        if ($urandom_range(0, 99) < 15) return READ_W'($urandom());
        jitter = $urandom_range(0, 160);
        target = setpoint * 4 - offset + jitter - 80;
        if (target < 0) target = 0;
        if (target > 4095) target = 4095;
        return READ_W'(target);
    endfunction

    initial begin
        int      sent;
        int      sp;
        int      ofs;
        t_action act;
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        in_bus.valid           = 1'b0;
        in_bus.action          = ACT_READING;
        in_bus.reading_quarter = '0;
        gaps_on                = 1'b1;
        sent                   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_registers(20, -400);
        offer_beat(ACT_MINUTE, '0);
        offer_beat(ACT_READING, 12'd398);   // mean of -0.5 degree rounds away from zero
        offer_beat(ACT_READING, 12'd0);
        offer_beat(ACT_CONTROL, '0);
        repeat (7) offer_beat(ACT_READING, 12'd4095);   // short ring wraps
        offer_beat(ACT_CONTROL, '0);
        repeat (3) offer_beat(ACT_MINUTE, 12'hFFF);
        offer_beat(ACT_READING, 12'd1);
        offer_beat(ACT_CLEAR, 12'hABC);
        offer_beat(ACT_CONTROL, '0);
        offer_beat(ACT_MINUTE, '0);

        set_registers(1023, 400);
        offer_beat(ACT_READING, 12'd4095);
        offer_beat(ACT_CONTROL, '0);
        offer_beat(ACT_MINUTE, '0);
        offer_beat(ACT_READING, 12'd0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin sp = 0;    ofs = -400; end
                1: begin sp = 1023; ofs = 400;  end
                2: begin sp = 512;  ofs = 0;    end
                default: begin
                    sp  = $urandom_range(0, 1023);
                    ofs = $urandom_range(0, 800);
                    ofs = ofs - 400;
                end
            endcase
            set_registers(sp, ofs);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                gaps_on = !(sent >= 400 && sent < 600);
                if (sent == 500) drain_results();
                act = pick_action();
                if (act == ACT_READING) offer_beat(act, pick_reading(sp, ofs));
                else offer_beat(act, READ_W'($urandom()));
                sent++;
            end
        end

        drain_results();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("averaged_thermostat_relay: match");
        end else begin
            $display("averaged_thermostat_relay: mismatch");
        end
        $finish;
    end

endmodule

FILE: averaged_thermostat_relay.f
hdl/atr_pkg.sv
hdl/atr_if.sv
hdl/atr_regs.sv
hdl/atr_div.sv
hdl/averaged_thermostat_relay.sv
tb/thermostat_checker.sv
tb/tb_top.sv
